FILE: hdl/sorted_list_insert_delete_top_macros.svh
// Assertion macros shared by the sorted list checker.
`ifndef SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLID_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLID_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/slid_pkg.sv
// Package: sizes, codes and the command bus of the sorted list.
`timescale 1ns / 1ps

package slid_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OUT_CW = 5;

	localparam logic       REQ_INSERT = 1'b0;
	localparam logic       REQ_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	// Command broadcast to every cell in a cycle
	typedef struct packed {
		logic               ins;
		logic               del;
		logic signed [31:0] v;
	} cmd_t;

	// Low bits of a count as shown on the result port
	function automatic logic [OUT_CW-1:0] cnt_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+OUT_CW-1:0] w;
		w = {{OUT_CW{1'b0}}, c};
		return w[OUT_CW-1:0];
	endfunction

endpackage

FILE: hdl/slid_cell.sv
// One slot of the sorted list: holds a value, shifts right on insert, left on delete.
`timescale 1ns / 1ps

module slid_cell (
	input  logic               clk,
	input  slid_pkg::cmd_t     cmd,
	input  logic               occ,
	input  logic               chain_in,
	input  logic signed [31:0] left_val,
	input  logic signed [31:0] right_val,
	output logic               chain_out,
	output logic signed [31:0] val
);

	logic signed [31:0] val_q;
	logic               hit;

	// insert: slot at or past the insertion point; delete: equal entry
	always_comb begin
		if (cmd.ins) begin
			hit = !occ || (val_q > cmd.v);
		end else begin
			hit = occ && (val_q == cmd.v);
		end
	end

	assign chain_out = chain_in || hit;
	assign val       = val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (chain_in) begin
				val_q <= left_val;
			end else if (hit) begin
				val_q <= cmd.v;
			end
		end else if (cmd.del && chain_out) begin
			val_q <= right_val;
		end
	end

endmodule

FILE: hdl/sorted_list_insert_delete_top.sv
// Sorted list of signed 32-bit values built as a chain of slot cells.
// Request channel: req_valid/req_stall with req_type (0 insert, 1 delete all
// equal) and value. Result channel: rsp_valid/rsp_stall with status, count,
// removed and smallest; exactly one result per request, in request order.
// Insert: the whole chain shifts when the request is taken and the result is
// registered; another request may follow at once unless the skid slot fills.
// Delete: one matching entry leaves the chain per cycle, and a final pass
// that finds none left ends it; the delete holds off requests meanwhile.
// The result register has a one-deep skid slot behind it: a request is taken
// while a result waits; req_stall is high while a delete runs or the skid
// slot is full. When rsp_stall is high the waiting result holds steady.
// Reset empties the list (count 0) and drops any pending result; slot values
// themselves are not cleared and are never shown unless written.
`timescale 1ns / 1ps

module sorted_list_insert_delete_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               req_type,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic [4:0]         removed,
	output logic signed [31:0] smallest
);

	localparam int D  = slid_pkg::DEPTH;
	localparam int CW = slid_pkg::CNT_W;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic [4:0]         removed;
		logic signed [31:0] smallest;
	} res_t;

	logic [CW-1:0]      fill_q;
	logic               busy_q;
	logic signed [31:0] del_val_q;
	logic [CW-1:0]      removed_q;
	logic               out_valid_q;
	res_t               out_q;
	logic               skid_valid_q;
	res_t               skid_q;

	slid_pkg::cmd_t     cmd;
	logic               req_fire;
	logic               full;
	logic               any_match;
	logic               res_valid;
	res_t               res;
	logic               out_fire;

	logic [D-1:0]       occ;
	logic [D-1:0]       chain;
	logic signed [31:0] vals [D];

	assign req_stall = busy_q || skid_valid_q;
	assign req_fire  = req_valid && !req_stall;
	assign full      = (fill_q == CW'(D));

	assign cmd.ins = req_fire && (req_type == slid_pkg::REQ_INSERT) && !full;
	assign cmd.del = busy_q;
	assign cmd.v   = busy_q ? del_val_q : value;

	genvar i;
	generate
		for (i = 0; i < D; i++) begin : g_cell
			logic               c_in;
			logic signed [31:0] l_val;
			logic signed [31:0] r_val;

			assign occ[i] = (fill_q > CW'(i));
			if (i == 0) begin : g_first
				assign c_in  = 1'b0;
				assign l_val = '0;
			end else begin : g_mid
				assign c_in  = chain[i-1];
				assign l_val = vals[i-1];
			end
			if (i == D - 1) begin : g_last
				assign r_val = '0;
			end else begin : g_inner
				assign r_val = vals[i+1];
			end

			slid_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occ       (occ[i]),
				.chain_in  (c_in),
				.left_val  (l_val),
				.right_val (r_val),
				.chain_out (chain[i]),
				.val       (vals[i])
			);
		end
	endgenerate

	// during a delete the chain end says some entry still matches
	assign any_match = chain[D-1];

	always_comb begin
		res_valid    = 1'b0;
		res.status   = slid_pkg::ST_DONE;
		res.count    = slid_pkg::cnt_out(fill_q);
		res.removed  = '0;
		res.smallest = (fill_q == '0) ? 32'sd0 : vals[0];
		if (req_fire && (req_type == slid_pkg::REQ_INSERT)) begin
			res_valid = 1'b1;
			if (full) begin
				res.status = slid_pkg::ST_FULL;
			end else begin
				res.count    = slid_pkg::cnt_out(fill_q + CW'(1));
				res.smallest = ((fill_q == '0) || (value < vals[0])) ? value : vals[0];
			end
		end else if (busy_q && !any_match) begin
			res_valid   = 1'b1;
			res.status  = (removed_q == '0) ? slid_pkg::ST_NOMATCH : slid_pkg::ST_DONE;
			res.removed = slid_pkg::cnt_out(removed_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			busy_q    <= 1'b0;
			removed_q <= '0;
		end else begin
			if (cmd.ins) begin
				fill_q <= fill_q + CW'(1);
			end
			if (req_fire && (req_type == slid_pkg::REQ_DELETE)) begin
				busy_q    <= 1'b1;
				removed_q <= '0;
			end else if (busy_q) begin
				if (any_match) begin
					fill_q    <= fill_q - CW'(1);
					removed_q <= removed_q + CW'(1);
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			del_val_q <= value;
		end
	end

	assign out_fire = out_valid_q && !rsp_stall;

	// results arrive only while the skid slot is empty, so order holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_q.status;
	assign count     = out_q.count;
	assign removed   = out_q.removed;
	assign smallest  = out_q.smallest;

endmodule

FILE: hdl/slid_checker.sv
// Port-level checks on the sorted list, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_top_macros.svh"

module slid_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [1:0]         status,
	input logic [4:0]         count,
	input logic [4:0]         removed,
	input logic signed [31:0] smallest
);

	`SLID_ASSERT_IMP(a_removed_done, rsp_valid && (removed != 5'd0), status == slid_pkg::ST_DONE, "removed entries without done status")
	`SLID_ASSERT_IMP(a_refused_none, rsp_valid && (status != slid_pkg::ST_DONE), removed == 5'd0, "failed request reports removals")
	`SLID_ASSERT_IMP(a_empty_zero, rsp_valid && (count == 5'd0), smallest == 32'sd0, "empty list shows nonzero smallest")
	`SLID_ASSERT_NXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(smallest), "stalled result changed")

endmodule

bind sorted_list_insert_delete_top slid_checker u_slid_checker (.*);

FILE: tb/tb_sorted_list_insert_delete_top.sv
// Testbench for the sorted list block: directed and random requests, checked against a shadow list.
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_BLOCKS  = 16;
	localparam int BLOCK_ITEMS    = 100;

	typedef struct {
		logic [1:0]         status;
		logic [4:0]         count;
		logic [4:0]         removed;
		logic signed [31:0] smallest;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               req_type;
	logic signed [31:0] value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [1:0]         status;
	logic [4:0]         count;
	logic [4:0]         removed;
	logic signed [31:0] smallest;

	logic signed [31:0] shadow_list[$];
	list_result_t       pending_results[$];
	logic signed [31:0] hot_vals[6];
	int                 mismatch_count;
	int                 idle_cycles;
	int                 stall_left;
	bit                 gaps_on;
	bit                 stalls_on;

	sorted_list_insert_delete_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.count     (count),
		.removed   (removed),
		.smallest  (smallest)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Shadow list update for one accepted request; returns the result it should produce
	function automatic list_result_t predict_list_request(input logic op,
			input logic signed [31:0] v);
		list_result_t       res;
		logic signed [31:0] kept[$];
		int                 pos;
		int                 gone;
		gone = 0;
		res.status = slid_pkg::ST_DONE;
		if (op == slid_pkg::REQ_INSERT) begin
			if (shadow_list.size() >= slid_pkg::DEPTH) begin
				res.status = slid_pkg::ST_FULL;
			end else begin
				pos = 0;
				// equal entries stay ahead of the new one
				while (pos < shadow_list.size() && shadow_list[pos] <= v)
					pos++;
				shadow_list.insert(pos, v);
			end
		end else begin
			foreach (shadow_list[i])
				if (shadow_list[i] != v)
					kept.push_back(shadow_list[i]);
			gone = shadow_list.size() - kept.size();
			shadow_list = kept;
			if (gone == 0)
				res.status = slid_pkg::ST_NOMATCH;
		end
		res.count    = 5'(shadow_list.size());
		res.removed  = 5'(gone);
		res.smallest = (shadow_list.size() > 0) ? shadow_list[0] : 32'sd0;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return hot_vals[$urandom_range(0, 5)];
		else if (r < 72)
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		else
			return $urandom;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_request(input logic op, input logic signed [31:0] v);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= op;
		value     <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(predict_list_request(op, v));
		@(negedge clk);
	endtask

	task automatic go_quiet();
		req_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		while (pending_results.size() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_empty_list();
		send_request(slid_pkg::REQ_DELETE, 32'sd0);
		send_request(slid_pkg::REQ_DELETE, 32'sh8000_0000);
	endtask

	task automatic test_extremes();
		send_request(slid_pkg::REQ_INSERT, 32'sh7FFF_FFFF);
		send_request(slid_pkg::REQ_INSERT, 32'sh8000_0000);
		send_request(slid_pkg::REQ_INSERT, 32'sd0);
		send_request(slid_pkg::REQ_INSERT, -32'sd1);
		send_request(slid_pkg::REQ_INSERT, 32'sd1);
		send_request(slid_pkg::REQ_DELETE, 32'sh8000_0000);
		send_request(slid_pkg::REQ_DELETE, 32'sh7FFF_FFFF);
	endtask

	task automatic test_full_refusal();
		while (shadow_list.size() < slid_pkg::DEPTH)
			send_request(slid_pkg::REQ_INSERT, 32'sd5);
		send_request(slid_pkg::REQ_INSERT, -32'sd7);
	endtask

	task automatic test_delete_duplicates();
		send_request(slid_pkg::REQ_DELETE, 32'sd5);
		send_request(slid_pkg::REQ_DELETE, 32'sd5);
	endtask

	// Bursts with the sender holding off until every result is back
	task automatic test_pause_until_drained();
		repeat (3) begin
			repeat (10)
				send_request(($urandom_range(0, 99) < 70) ?
					slid_pkg::REQ_INSERT : slid_pkg::REQ_DELETE, pick_value());
			go_quiet();
			wait_for_drain();
		end
	endtask

	task automatic test_random_mix();
		int                 ins_pct;
		logic               op;
		logic signed [31:0] v;
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			foreach (hot_vals[i])
				hot_vals[i] = $urandom;
			case ($urandom_range(0, 2))
				0: ins_pct = 30;
				1: ins_pct = 55;
				default: ins_pct = 85;
			endcase
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			repeat (BLOCK_ITEMS) begin
				op = ($urandom_range(0, 99) < ins_pct) ?
					slid_pkg::REQ_INSERT : slid_pkg::REQ_DELETE;
				if (op == slid_pkg::REQ_DELETE && shadow_list.size() > 0 &&
						$urandom_range(0, 1))
					v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
				else
					v = pick_value();
				send_request(op, v);
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stalls_on && $urandom_range(0, 99) < 25) begin
			rsp_stall  <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: status %0d count %0d",
					status, count));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
				if (removed !== want.removed)
					report_mismatch($sformatf("removed %0d, expected %0d", removed,
						want.removed));
				if (smallest !== want.smallest)
					report_mismatch($sformatf("smallest %0d, expected %0d", smallest,
						want.smallest));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", idle_cycles);
				$display("sorted_list_insert_delete_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req_type       = slid_pkg::REQ_INSERT;
		value          = 32'sd0;
		rsp_stall      = 1'b0;
		stall_left     = 0;
		idle_cycles    = 0;
		mismatch_count = 0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;
		foreach (hot_vals[i])
			hot_vals[i] = $urandom;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_list();
		test_extremes();
		test_full_refusal();
		test_delete_duplicates();
		test_pause_until_drained();
		test_random_mix();
		go_quiet();

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sorted_list_insert_delete_top regression: pass");
		else
			$display("sorted_list_insert_delete_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/slid_pkg.sv
hdl/slid_cell.sv
hdl/sorted_list_insert_delete_top.sv
hdl/slid_checker.sv
tb/tb_sorted_list_insert_delete_top.sv
